FILE: design/b2da_pkg.sv
// Package for the binary to decimal ASCII core: sizing constants and the
// command/status structs shared by the controller and the datapath.
// No dependencies.
package b2da_pkg;

   localparam int VALUE_WIDTH    = 32;
   localparam int MAX_DIGITS     = 10;
   localparam int BITS_PER_CYCLE = 4;

   localparam int CONV_STEPS  = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
   localparam int PAD_W       = CONV_STEPS * BITS_PER_CYCLE;
   // decimal digits of the widest value: floor(width * log10(2)) + 1
   localparam int BCD_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int BCD_W       = 4 * BCD_DIGITS;
   localparam int IDX_W       = $clog2(BCD_DIGITS);
   localparam int EMIT_DIGITS = (MAX_DIGITS < BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS;
   localparam int STEP_W      = $clog2(CONV_STEPS + 1);

   localparam int CHAR_W = 6;
   localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

   typedef struct packed {
      logic load;
      logic convert;
      logic locate;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic idx_zero;
   } status_type;

endpackage

FILE: design/b2da_ctrl.sv
// Controller for the binary to decimal ASCII core: sequences load, the
// shift-add-3 steps, leading-zero location and digit output. Uses b2da_pkg.
module b2da_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  b2da_pkg::status_type status,
   output b2da_pkg::cmd_type    cmd
);
   import b2da_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_CONVERT = 4'b0010,
      ST_LOCATE  = 4'b0100,
      ST_EMIT    = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               step_in  = STEP_W'(CONV_STEPS - 1);
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.convert = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_LOCATE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_LOCATE: begin
            cmd.locate = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.idx_zero) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

FILE: design/b2da_datapath.sv
// Datapath for the binary to decimal ASCII core: shift-add-3 BCD register,
// leading-zero priority encoder and digit output mux. Uses b2da_pkg.
module b2da_datapath (
   input  logic                           clock,
   input  logic [b2da_pkg::VALUE_WIDTH-1:0] value,
   input  b2da_pkg::cmd_type              cmd,
   output b2da_pkg::status_type           status,
   output logic                           rsp_strobe,
   output logic [b2da_pkg::CHAR_W-1:0]    rsp_digit_char,
   output logic                           rsp_last_digit
);
   import b2da_pkg::*;

   localparam logic [IDX_W-1:0] TOP_LIMIT = IDX_W'(EMIT_DIGITS - 1);

   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic [PAD_W-1:0] bin_ff, bin_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic [BCD_W-1:0] bcd_step;
   logic [PAD_W-1:0] bin_step;
   logic [IDX_W-1:0] top_idx;
   logic [3:0]       cur_digit;

   // BITS_PER_CYCLE shift-add-3 iterations per cycle
   always_comb begin
      bcd_step = bcd_ff;
      bin_step = bin_ff;
      for (int b = 0; b < BITS_PER_CYCLE; b++) begin
         for (int d = 0; d < BCD_DIGITS; d++) begin
            if (bcd_step[d*4 +: 4] >= 4'd5) begin
               bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + 4'd3;
            end
         end
         {bcd_step, bin_step} = {bcd_step, bin_step} << 1;
      end
   end

   // most significant nonzero digit, clipped to the output digit limit
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] != 4'd0) begin
            top_idx = IDX_W'(i);
         end
      end
      if (top_idx > TOP_LIMIT) begin
         top_idx = TOP_LIMIT;
      end
   end

   always_comb begin
      bcd_in = bcd_ff;
      bin_in = bin_ff;
      idx_in = idx_ff;
      if (cmd.load) begin
         bcd_in = '0;
         bin_in = PAD_W'(value);
      end else if (cmd.convert) begin
         bcd_in = bcd_step;
         bin_in = bin_step;
      end
      if (cmd.locate) begin
         idx_in = top_idx;
      end else if (cmd.emit && idx_ff != '0) begin
         idx_in = idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
      bin_ff <= bin_in;
      idx_ff <= idx_in;
   end

   assign cur_digit       = bcd_ff[idx_ff*4 +: 4];
   assign status.idx_zero = (idx_ff == '0);
   assign rsp_strobe      = cmd.emit;
   assign rsp_digit_char  = ASCII_ZERO + {{(CHAR_W-4){1'b0}}, cur_digit};
   assign rsp_last_digit  = (idx_ff == '0);

endmodule

FILE: design/binary_to_decimal_ascii_core.sv
// Binary to decimal ASCII converter, top level.
// Uses b2da_pkg, b2da_ctrl and b2da_datapath.
//
// Usage: drive req_value and raise start; the word is taken at a rising
// edge where start is high and busy is low. busy stays high until the
// last digit has been sent. The number is converted to BCD by a shift-add-3
// register working four bits per cycle, the leading nonzero digit is then
// located, and the digits leave one per cycle, most significant first, as
// ASCII codes on rsp_digit_char with rsp_strobe high for exactly that cycle.
// rsp_last_digit marks the least significant digit. Zero gives the single
// digit '0'. A new word is taken only after the last digit of the previous
// one has been sent.
// The receiver cannot stall: every strobed digit is taken as it appears.
// Synchronous reset returns the controller to idle and drops any run in
// progress; no digit is strobed until a new word is taken.
module binary_to_decimal_ascii_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [b2da_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                             rsp_strobe,
   output logic [b2da_pkg::CHAR_W-1:0]      rsp_digit_char,
   output logic                             rsp_last_digit
);
   import b2da_pkg::*;

   cmd_type    cmd;
   status_type status;

   b2da_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   b2da_datapath u_datapath (
      .clock          (clock),
      .value          (req_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_strobe     (rsp_strobe),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

endmodule

FILE: verif/testbench.sv
// Testbench for binary_to_decimal_ascii_core: drives words to convert through the start/busy port,
// predicts the ASCII digits of each and checks every strobed digit in order.
// Depends on b2da_pkg and the core RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import b2da_pkg::*;

   localparam int DIGIT_SLOTS    = 20;
   localparam int DIRECTED_ROWS  = 18;
   localparam int RANDOM_WORDS   = 192;
   localparam int DRAIN_CYCLES   = 30;

   typedef struct {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } digit_word_type;

   typedef struct {
      logic [VALUE_WIDTH-1:0] value;
      string                  text;
   } directed_row_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [VALUE_WIDTH-1:0] req_value;
   logic                   rsp_strobe;
   logic [CHAR_W-1:0]      rsp_digit_char;
   logic                   rsp_last_digit;

   digit_word_type   pending_digits [$];
   directed_row_type directed_rows [DIRECTED_ROWS];
   int               error_count;
   bit               idling_on;

   binary_to_decimal_ascii_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // Decimal digits of v, most significant first, capped at MAX_DIGITS low digits.
   function automatic void queue_decimal_digits(input logic [VALUE_WIDTH-1:0] v);
      logic [63:0] rest;
      int unsigned lows [DIGIT_SLOTS];
      int count;
      int lim;
      int top;
      int k;
      digit_word_type w;
      rest  = 64'(v);
      count = 0;
      do begin
         lows[count] = int'(rest % 10);
         rest = rest / 10;
         count++;
      end while (rest != 0 && count < DIGIT_SLOTS);
      lim = (MAX_DIGITS > DIGIT_SLOTS) ? DIGIT_SLOTS : MAX_DIGITS;
      if (lim < 1) lim = 1;
      top = count - 1;
      if (count > lim) begin
         top   = lim - 1;
         count = lim;
      end
      for (k = 0; k < count; k++) begin
         w.ch   = CHAR_W'(lows[top - k]) + ASCII_ZERO;
         w.last = (k == count - 1);
         pending_digits.push_back(w);
      end
   endfunction

   function automatic void queue_typed_digits(input string text);
      digit_word_type w;
      for (int i = 0; i < text.len(); i++) begin
         w.ch   = CHAR_W'(text[i]);
         w.last = (i == text.len() - 1);
         pending_digits.push_back(w);
      end
   endfunction

   // Offer one word until the core takes it; gaps fall at random while enabled.
   task automatic send_word(input logic [VALUE_WIDTH-1:0] v, input string text);
      bit taken;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         if (idling_on && $urandom_range(0, 99) < 25) begin
            start     = 1'b0;
            req_value = $urandom;
         end else begin
            start     = 1'b1;
            req_value = v;
         end
         @(posedge clock);
         if (start && !busy) begin
            taken = 1'b1;
            if (text.len() != 0) queue_typed_digits(text);
            else queue_decimal_digits(v);
         end
      end
   endtask

   // Hold off the sender until every outstanding digit has come back.
   task automatic drain_digits();
      @(negedge clock);
      start = 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
   endtask

   function automatic logic [VALUE_WIDTH-1:0] random_value();
      logic [VALUE_WIDTH-1:0] p;
      int k;
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom >> $urandom_range(0, 31);
         2: begin
            k = $urandom_range(1, 9);
            p = 1;
            repeat (k) p = p * 10;
            return p - 1 + $urandom_range(0, 2);
         end
         default: return $urandom_range(0, 999);
      endcase
   endfunction

   always @(posedge clock) begin
      digit_word_type w;
      if (!reset) begin
         if ($isunknown(rsp_strobe)) begin
            report_mismatch("rsp_strobe unknown");
         end else if (rsp_strobe) begin
            if (pending_digits.size() == 0) begin
               report_mismatch($sformatf("unexpected digit %0d", rsp_digit_char));
            end else begin
               w = pending_digits.pop_front();
               if (rsp_digit_char !== w.ch)
                  report_mismatch($sformatf("digit_char %0d, want %0d", rsp_digit_char, w.ch));
               if (rsp_last_digit !== w.last)
                  report_mismatch($sformatf("last_digit %0b, want %0b", rsp_last_digit, w.last));
            end
         end
      end
   end

   initial begin
      error_count = 0;
      idling_on   = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_value   = '0;
      directed_rows = '{
         '{32'd0,          "0"},
         '{32'd4294967295, "4294967295"},
         '{32'd1,          "1"},
         '{32'd9,          "9"},
         '{32'd10,         "10"},
         '{32'd99,         ""},
         '{32'd100,        ""},
         '{32'd999999999,  ""},
         '{32'd1000000000, "1000000000"},
         '{32'h80000000,   ""},
         '{32'h55555555,   ""},
         '{32'hAAAAAAAA,   ""},
         '{32'hFFFFFFFE,   ""},
         '{32'd4000000000, ""},
         '{32'd1234567890, ""},
         '{32'd101,        ""},
         '{32'd0,          "0"},
         '{32'd7,          "7"}
      };
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) send_word(directed_rows[i].value, directed_rows[i].text);
      drain_digits();

      idling_on = 1'b1;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         // long back-to-back stretch in the middle
         idling_on = !(n >= 60 && n < 120);
         if (n == 140) drain_digits();
         send_word(random_value(), "");
      end
      @(negedge clock);
      start = 1'b0;

      while (pending_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_digits.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
